// File: sv/tild_pkg.sv
// Shared types and constants for the terminal input line discipline.
// Used by the front classifier, the command queue, the back executor and the top level.
package tild_pkg;

    localparam int LEN_W = 6;   // line length counter width
    localparam int CNT_W = 7;   // result counter width per command
    localparam int PRE_N = 4;   // fixed results a command can carry ahead of its tail

    // configuration register indexes
    localparam logic [2:0] CFG_INPUT_FLAGS  = 3'd0;
    localparam logic [2:0] CFG_LOCAL_FLAGS  = 3'd1;
    localparam logic [2:0] CFG_SIGNAL_CHARS = 3'd2;
    localparam logic [2:0] CFG_FLOW_CHARS   = 3'd3;
    localparam logic [2:0] CFG_EDIT_CHARS   = 3'd4;
    localparam logic [2:0] CFG_PACKET_MODE  = 3'd5;
    localparam logic [2:0] CFG_SIG_TARGET   = 3'd6;

    // reset values
    localparam logic [4:0]  RST_INPUT_FLAGS  = 5'd20;
    localparam logic [6:0]  RST_LOCAL_FLAGS  = 7'd127;
    localparam logic [23:0] RST_SIGNAL_CHARS = 24'd1711107;
    localparam logic [15:0] RST_FLOW_CHARS   = 16'd4371;
    localparam logic [31:0] RST_EDIT_CHARS   = 32'd1408772;

    // result destinations
    localparam logic [1:0] DEST_ECHO   = 2'd0;
    localparam logic [1:0] DEST_DATA   = 2'd1;
    localparam logic [1:0] DEST_SIGNAL = 2'd2;
    localparam logic [1:0] DEST_EOF    = 2'd3;

    // signal codes
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_QUIT = 2'd2;
    localparam logic [1:0] SIG_SUSP = 2'd3;

    // characters
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CTL_OFFSET = 8'h40;
    localparam logic [7:0] PKT_STOP   = 8'h04;
    localparam logic [7:0] PKT_START  = 8'h08;

    typedef struct packed {
        logic [4:0]  input_flags;
        logic [6:0]  local_flags;
        logic [23:0] signal_chars;
        logic [15:0] flow_chars;
        logic [31:0] edit_chars;
        logic        packet_mode;
        logic        sig_target;
    } cfg_t;

    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] value;
        logic [1:0] sig;
    } res_t;

    // one classified byte: fixed results, then a tail that walks the line store
    typedef struct packed {
        res_t [PRE_N-1:0] pre;
        logic [2:0]       npre;
        logic             deliver;   // tail is line data, else backspace rubouts
        logic [LEN_W-1:0] tail_n;
        logic             wr_en;
        logic [LEN_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             stopped;
    } cmd_t;

endpackage

// File: sv/tild_front.sv
// Front end: input processing and classification of each received byte into a command.
// Owns line length and flow state. Depends on tild_pkg.
module tild_front
    import tild_pkg::*;
#(
    parameter int LINE_CAPACITY = 60
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic [LEN_W-1:0] len_reg, len_next, len_st;
    logic             stopped_reg, stopped_next;
    logic [7:0]       c;
    logic [1:0]       sig;
    logic             ign, need, accept;
    cmd_t             cmd;

    function automatic cmd_t push_res(cmd_t cm, logic [1:0] d, logic [7:0] v, logic [1:0] s);
        res_t r;
        r.dest  = d;
        r.value = v;
        r.sig   = s;
        cm.pre[cm.npre[1:0]] = r;
        cm.npre = cm.npre + 3'd1;
        return cm;
    endfunction

    function automatic cmd_t echo_out(cmd_t cm, logic [7:0] v, logic stp);
        if (!stp) begin
            cm = push_res(cm, DEST_ECHO, v, SIG_NONE);
        end
        return cm;
    endfunction

    function automatic cmd_t echo_byte(cmd_t cm, logic [7:0] ch, logic [6:0] lf, logic stp);
        if (lf[2]) begin
            if (lf[5] && ch < CH_SPACE && ch != CH_NL && ch != CH_CR && ch != CH_TAB) begin
                cm = echo_out(cm, CH_CARET, stp);
                cm = echo_out(cm, ch + CTL_OFFSET, stp);
            end else if (lf[5] && ch == CH_DEL) begin
                cm = echo_out(cm, CH_CARET, stp);
                cm = echo_out(cm, CH_QMARK, stp);
            end else begin
                cm = echo_out(cm, ch, stp);
            end
        end
        return cm;
    endfunction

    always_comb begin
        c = s_tdata;
        if (cfg.input_flags[0]) begin
            c[7] = 1'b0;
        end
        ign = 1'b0;
        if (c == CH_CR) begin
            if (cfg.input_flags[1]) begin
                ign = 1'b1;
            end else if (cfg.input_flags[2]) begin
                c = CH_NL;
            end
        end else if (c == CH_NL && cfg.input_flags[3]) begin
            c = CH_CR;
        end

        sig = SIG_NONE;
        if (cfg.local_flags[0]) begin
            if (c == cfg.signal_chars[7:0]) begin
                sig = SIG_INTR;
            end else if (c == cfg.signal_chars[15:8]) begin
                sig = SIG_QUIT;
            end else if (c == cfg.signal_chars[23:16]) begin
                sig = SIG_SUSP;
            end
        end

        cmd          = '0;
        len_next     = len_reg;
        len_st       = len_reg;
        stopped_next = stopped_reg;

        if (ign) begin
            cmd = '0;
        end else if (sig != SIG_NONE) begin
            cmd = echo_byte(cmd, c, cfg.local_flags, stopped_reg);
            if (cfg.local_flags[2]) begin
                cmd = echo_out(cmd, CH_NL, stopped_reg);
            end
            len_next = '0;
            if (cfg.sig_target) begin
                cmd = push_res(cmd, DEST_SIGNAL, 8'd0, sig);
            end
        end else if (cfg.input_flags[4] && c == cfg.flow_chars[7:0] && !stopped_reg) begin
            stopped_next = 1'b1;
            if (cfg.packet_mode) begin
                cmd = push_res(cmd, DEST_ECHO, PKT_STOP, SIG_NONE);
            end
        end else if (cfg.input_flags[4] && c == cfg.flow_chars[15:8] && stopped_reg) begin
            stopped_next = 1'b0;
            if (cfg.packet_mode) begin
                cmd = push_res(cmd, DEST_ECHO, PKT_START, SIG_NONE);
            end
        end else if (!cfg.local_flags[1]) begin
            cmd = echo_byte(cmd, c, cfg.local_flags, stopped_reg);
            cmd = push_res(cmd, DEST_DATA, c, SIG_NONE);
        end else if (c == cfg.edit_chars[7:0]) begin
            if (len_reg != '0) begin
                cmd.deliver = 1'b1;
                cmd.tail_n  = len_reg;
                len_next    = '0;
            end else begin
                cmd = push_res(cmd, DEST_EOF, 8'd0, SIG_NONE);
            end
        end else if (c == cfg.edit_chars[15:8]) begin
            if (len_reg != '0) begin
                len_next = len_reg - 1'b1;
                if (cfg.local_flags[3] && cfg.local_flags[2]) begin
                    cmd = echo_out(cmd, CH_BS, stopped_reg);
                end
            end
        end else if (c == cfg.edit_chars[23:16]) begin
            len_next = '0;
            if (cfg.local_flags[6]) begin
                // one backspace per stored byte, walked by the back end
                if (cfg.local_flags[3] && cfg.local_flags[2] && !stopped_reg) begin
                    cmd.tail_n = len_reg;
                end
            end else if (cfg.local_flags[4] && cfg.local_flags[2]) begin
                cmd = echo_out(cmd, CH_NL, stopped_reg);
            end
        end else begin
            cmd = echo_byte(cmd, c, cfg.local_flags, stopped_reg);
            if (len_reg < LEN_W'(LINE_CAPACITY)) begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = len_reg;
                cmd.wr_data = c;
                len_st      = len_reg + 1'b1;
            end
            if (c == CH_NL || c == cfg.edit_chars[31:24]) begin
                cmd.deliver = 1'b1;
                cmd.tail_n  = len_st;
                len_next    = '0;
            end else begin
                len_next = len_st;
            end
        end
        cmd.stopped = stopped_next;
    end

    assign need     = (cmd.npre != 3'd0) || (cmd.tail_n != '0) || cmd.wr_en;
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && need;
    assign q_cmd    = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            stopped_reg <= 1'b0;
        end else if (accept) begin
            len_reg     <= len_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// File: sv/tild_cmd_fifo.sv
// Two-entry command queue between the front classifier and the back executor.
// Depends on tild_pkg for cmd_t.
module tild_cmd_fifo
    import tild_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = count_reg == 2'd2;
    assign avail   = count_reg != 2'd0;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: sv/tild_back.sv
// Back end: executes queued commands, owns the line store and the output register.
// Emits one result word per cycle while a command runs and the receiver accepts. Depends on tild_pkg.
module tild_back
    import tild_pkg::*;
#(
    parameter int LINE_CAPACITY = 60
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_avail,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res,
    output logic out_stopped,
    output logic out_last
);

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [7:0]       store_mem [LINE_CAPACITY];
    logic [7:0]       rd_q_reg;
    logic             state_reg;
    cmd_t             cur_reg;
    logic [CNT_W-1:0] k_reg, total;
    logic [LEN_W-1:0] t_reg, t_next;
    logic             can_load, emit, is_pre, last, wr_now;
    res_t             res;
    logic             out_valid_reg, out_stopped_reg, out_last_reg;
    res_t             out_res_reg;

    assign total    = CNT_W'(cur_reg.npre) + CNT_W'(cur_reg.tail_n);
    assign can_load = !out_valid_reg || out_ready;
    assign emit     = (state_reg == ST_RUN) && can_load;
    assign is_pre   = k_reg < CNT_W'(cur_reg.npre);
    assign last     = k_reg == (total - 1'b1);
    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_avail;
    assign wr_now   = cmd_pop && cmd.wr_en;

    always_comb begin
        if (cmd_pop) begin
            t_next = '0;
        end else if (emit && !is_pre) begin
            t_next = t_reg + 1'b1;
        end else begin
            t_next = t_reg;
        end
    end

    always_comb begin
        if (is_pre) begin
            res = cur_reg.pre[k_reg[1:0]];
        end else if (cur_reg.deliver) begin
            res.dest  = DEST_DATA;
            res.value = rd_q_reg;
            res.sig   = SIG_NONE;
        end else begin
            res.dest  = DEST_ECHO;
            res.value = CH_BS;
            res.sig   = SIG_NONE;
        end
    end

    // line store; read data follows the tail index, with write-through on a same-cycle hit
    always_ff @(posedge aclk) begin
        if (wr_now) begin
            store_mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        end
        if (wr_now && cmd.wr_addr == t_next) begin
            rd_q_reg <= cmd.wr_data;
        end else if (t_next < LEN_W'(LINE_CAPACITY)) begin
            rd_q_reg <= store_mem[t_next[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            t_reg     <= '0;
        end else begin
            t_reg <= t_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_pop) begin
                        k_reg <= '0;
                        if (cmd.npre != 3'd0 || cmd.tail_n != '0) begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (emit) begin
                        k_reg <= k_reg + 1'b1;
                        if (last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            cur_reg <= cmd;
        end
        if (emit) begin
            out_res_reg     <= res;
            out_stopped_reg <= cur_reg.stopped;
            out_last_reg    <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_res     = out_res_reg;
    assign out_stopped = out_stopped_reg;
    assign out_last    = out_last_reg;

endmodule

// File: sv/terminal_input_line_discipline_top.sv
// Terminal input line discipline: input processing, signal and flow keys, line editing.
// Top level: configuration registers, front classifier, command queue, back executor.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry typed bytes in, one byte per word.
//   m_tvalid/m_tready/m_tdata/m_tuser/m_tlast carry results out; m_tlast marks
//   the final result word caused by one input byte. Bytes that cause nothing
//   (ignored CR, erase on an empty line, echo while stopped) produce no word.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write configuration register
//   cfg_index; cfg_ready is always high, indexes past the list are ignored.
// Timing:
//   The front classifies a byte in the cycle it is accepted and queues a command.
//   The back takes one command at a time and emits all its result words before it
//   takes the next; line delivery and kill rubout walk the line store one byte per
//   cycle while the receiver accepts. The first result word passes through the
//   queue entry, the back's command register and the output register. The front
//   keeps taking bytes while the two-entry queue has room.
// Reset: configuration returns to defaults, the line is empty, output running.
//   The line store is not cleared. A stalled receiver holds the output word and
//   backs up the queue, which then deasserts s_tready.
module terminal_input_line_discipline_top
    import tild_pkg::*;
#(
    parameter int LINE_CAPACITY = 60
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] value, [8] output_stopped, [15:9] zero
    output logic [3:0]  m_tuser,     // [1:0] destination, [3:2] signal_code
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_full, q_push, q_avail, q_pop;
    cmd_t q_in, q_out;
    res_t res;
    logic res_stopped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.input_flags  <= RST_INPUT_FLAGS;
            cfg_reg.local_flags  <= RST_LOCAL_FLAGS;
            cfg_reg.signal_chars <= RST_SIGNAL_CHARS;
            cfg_reg.flow_chars   <= RST_FLOW_CHARS;
            cfg_reg.edit_chars   <= RST_EDIT_CHARS;
            cfg_reg.packet_mode  <= 1'b0;
            cfg_reg.sig_target   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_INPUT_FLAGS:  cfg_reg.input_flags  <= cfg_data[4:0];
                CFG_LOCAL_FLAGS:  cfg_reg.local_flags  <= cfg_data[6:0];
                CFG_SIGNAL_CHARS: cfg_reg.signal_chars <= cfg_data[23:0];
                CFG_FLOW_CHARS:   cfg_reg.flow_chars   <= cfg_data[15:0];
                CFG_EDIT_CHARS:   cfg_reg.edit_chars   <= cfg_data;
                CFG_PACKET_MODE:  cfg_reg.packet_mode  <= cfg_data[0];
                CFG_SIG_TARGET:   cfg_reg.sig_target   <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    tild_front #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_in)
    );

    tild_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(q_in),
        .full    (q_full),
        .pop     (q_pop),
        .avail   (q_avail),
        .pop_cmd (q_out)
    );

    tild_back #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_avail  (q_avail),
        .cmd        (q_out),
        .cmd_pop    (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res),
        .out_stopped(res_stopped),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'd0, res_stopped, res.value};
    assign m_tuser = {res.sig, res.dest};

endmodule

// File: sv/tild_checker.sv
// Port-level checker for the terminal input line discipline, bound to the top level.
// Sees only top-level ports; no package dependency.
module tild_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // signal and end-of-file words carry no byte
    a_novalue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero value on signal or end-of-file word");

    // a signal code appears exactly on signal words
    a_sigcode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser[1:0] == 2'd2) == (m_tuser[3:2] != 2'd0)))
        else $error("signal code does not match destination");

    // a signal word always ends its byte's results
    a_siglast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == 2'd2 |-> m_tlast)
        else $error("signal word not last");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind terminal_input_line_discipline_top tild_checker u_tild_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for terminal_input_line_discipline_top: typed bytes in, echo/data/signal
// words out, checked against an in-bench line discipline predictor. Needs tild_pkg.
module testbench;
    import tild_pkg::*;

    localparam int LINE_CAP = 60;
    localparam int MAX_WORDS = 64;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 160;
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

    // input_flags bits
    localparam int IF_STRIP = 0;
    localparam int IF_IGNCR = 1;
    localparam int IF_ICRNL = 2;
    localparam int IF_INLCR = 3;
    localparam int IF_IXON  = 4;
    // local_flags bits
    localparam int LF_ISIG    = 0;
    localparam int LF_ICANON  = 1;
    localparam int LF_ECHO    = 2;
    localparam int LF_ECHOE   = 3;
    localparam int LF_ECHOK   = 4;
    localparam int LF_ECHOCTL = 5;
    localparam int LF_ECHOKE  = 6;

    typedef struct {
        logic [1:0] dest;
        logic [7:0] value;
        logic [1:0] sig;
        logic       stopped;
        logic       last;
    } result_word_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data = 32'd0;

    terminal_input_line_discipline_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    cfg_t       shadow_cfg = '{RST_INPUT_FLAGS, RST_LOCAL_FLAGS, RST_SIGNAL_CHARS,
                               RST_FLOW_CHARS, RST_EDIT_CHARS, 1'b0, 1'b0};
    logic [7:0] line_buf [LINE_CAP];
    logic [5:0] line_fill = '0;
    logic       out_stopped = 1'b0;

    result_word_t step_words[$];
    result_word_t expected_words[$];
    logic [7:0]   byte_q[$];

    int  fail_count = 0;
    bit  s_took = 1'b0;
    bit  bursts_on = 1'b1;
    int  src_gap = 0;
    int  sink_gap = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic void put_word(logic [1:0] dest, logic [7:0] val, logic [1:0] sig);
        result_word_t w;
        if (step_words.size() < MAX_WORDS) begin
            w.dest = dest;
            w.value = val;
            w.sig = sig;
            w.stopped = 1'b0;
            w.last = 1'b0;
            step_words.push_back(w);
        end
    endfunction

    function automatic void send_echo(logic [7:0] b);
        if (!out_stopped)
            put_word(DEST_ECHO, b, SIG_NONE);
    endfunction

    function automatic void echo_key(logic [7:0] c);
        logic ctl;
        ctl = shadow_cfg.local_flags[LF_ECHOCTL];
        if (!shadow_cfg.local_flags[LF_ECHO])
            return;
        if (ctl && c < CH_SPACE && c != CH_NL && c != CH_CR && c != CH_TAB) begin
            send_echo(CH_CARET);
            send_echo(c + CTL_OFFSET);
        end else if (ctl && c == CH_DEL) begin
            send_echo(CH_CARET);
            send_echo(CH_QMARK);
        end else begin
            send_echo(c);
        end
    endfunction

    function automatic void echo_backspace();
        if (shadow_cfg.local_flags[LF_ECHO] && shadow_cfg.local_flags[LF_ECHOE])
            send_echo(CH_BS);
    endfunction

    function automatic void store_key(logic [7:0] c);
        if (line_fill < LINE_CAP) begin
            line_buf[line_fill] = c;
            line_fill++;
        end
    endfunction

    function automatic void deliver_line();
        for (int i = 0; i < line_fill; i++)
            put_word(DEST_DATA, line_buf[i], SIG_NONE);
        line_fill = '0;
    endfunction

    // fills step_words with the words one typed byte causes, updates line state
    function automatic void predict_words(logic [7:0] raw);
        logic [7:0] c;
        logic [1:0] sig;
        logic [6:0] lf;
        c = raw;
        sig = SIG_NONE;
        lf = shadow_cfg.local_flags;
        if (shadow_cfg.input_flags[IF_STRIP])
            c[7] = 1'b0;
        if (c == CH_CR) begin
            if (shadow_cfg.input_flags[IF_IGNCR])
                return;
            if (shadow_cfg.input_flags[IF_ICRNL])
                c = CH_NL;
        end else if (c == CH_NL && shadow_cfg.input_flags[IF_INLCR]) begin
            c = CH_CR;
        end

        if (lf[LF_ISIG]) begin
            if (c == shadow_cfg.signal_chars[7:0])
                sig = SIG_INTR;
            else if (c == shadow_cfg.signal_chars[15:8])
                sig = SIG_QUIT;
            else if (c == shadow_cfg.signal_chars[23:16])
                sig = SIG_SUSP;
            if (sig != SIG_NONE) begin
                echo_key(c);
                if (lf[LF_ECHO])
                    send_echo(CH_NL);
                line_fill = '0;
                if (shadow_cfg.sig_target)
                    put_word(DEST_SIGNAL, 8'h00, sig);
                return;
            end
        end

        if (shadow_cfg.input_flags[IF_IXON]) begin
            if (c == shadow_cfg.flow_chars[7:0] && !out_stopped) begin
                out_stopped = 1'b1;
                // status byte goes out even though output just stopped
                if (shadow_cfg.packet_mode)
                    put_word(DEST_ECHO, PKT_STOP, SIG_NONE);
                return;
            end
            if (c == shadow_cfg.flow_chars[15:8] && out_stopped) begin
                out_stopped = 1'b0;
                if (shadow_cfg.packet_mode)
                    send_echo(PKT_START);
                return;
            end
        end

        if (!lf[LF_ICANON]) begin
            echo_key(c);
            put_word(DEST_DATA, c, SIG_NONE);
            return;
        end

        if (c == shadow_cfg.edit_chars[7:0]) begin
            if (line_fill != 0)
                deliver_line();
            else
                put_word(DEST_EOF, 8'h00, SIG_NONE);
            return;
        end

        if (c == shadow_cfg.edit_chars[15:8]) begin
            if (line_fill != 0) begin
                line_fill--;
                echo_backspace();
            end
            return;
        end

        if (c == shadow_cfg.edit_chars[23:16]) begin
            if (lf[LF_ECHOKE]) begin
                while (line_fill != 0) begin
                    line_fill--;
                    echo_backspace();
                end
            end else begin
                line_fill = '0;
                if (lf[LF_ECHOK] && lf[LF_ECHO])
                    send_echo(CH_NL);
            end
            return;
        end

        echo_key(c);
        store_key(c);
        if (c == CH_NL || c == shadow_cfg.edit_chars[31:24])
            deliver_line();
    endfunction

    // ---------------- input driver ----------------
    always @(negedge aclk) begin
        if (!s_tvalid || s_took) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                s_tdata <= byte_q.pop_front();
                s_tvalid <= 1'b1;
                if (bursts_on && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 6);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result sink ----------------
    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (bursts_on && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 6);
        end
    end

    // ---------------- monitor and scoreboard ----------------
    always @(posedge aclk) begin : monitor
        result_word_t want;
        s_took = aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: destination %0d value %02h", m_tuser[1:0], m_tdata[7:0]);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (m_tuser[1:0] !== want.dest) begin
                    $error("destination: expected %0d, got %0d", want.dest, m_tuser[1:0]);
                    fail_count++;
                end
                if (m_tdata[7:0] !== want.value) begin
                    $error("value: expected %02h, got %02h", want.value, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tuser[3:2] !== want.sig) begin
                    $error("signal_code: expected %0d, got %0d", want.sig, m_tuser[3:2]);
                    fail_count++;
                end
                if (m_tdata[8] !== want.stopped) begin
                    $error("output_stopped: expected %0d, got %0d", want.stopped, m_tdata[8]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
        if (s_took) begin
            step_words.delete();
            predict_words(s_tdata);
            foreach (step_words[k]) begin
                step_words[k].stopped = out_stopped;
                step_words[k].last = (k == step_words.size() - 1);
                expected_words.push_back(step_words[k]);
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_INPUT_FLAGS:  shadow_cfg.input_flags = val[4:0];
            CFG_LOCAL_FLAGS:  shadow_cfg.local_flags = val[6:0];
            CFG_SIGNAL_CHARS: shadow_cfg.signal_chars = val[23:0];
            CFG_FLOW_CHARS:   shadow_cfg.flow_chars = val[15:0];
            CFG_EDIT_CHARS:   shadow_cfg.edit_chars = val;
            CFG_PACKET_MODE:  shadow_cfg.packet_mode = val[0];
            CFG_SIG_TARGET:   shadow_cfg.sig_target = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [4:0] inf, input logic [6:0] lf,
                                  input logic [23:0] sc, input logic [15:0] fc,
                                  input logic [31:0] ec, input logic pm, input logic st);
        write_reg(CFG_INPUT_FLAGS, 32'(inf));
        write_reg(CFG_LOCAL_FLAGS, 32'(lf));
        write_reg(CFG_SIGNAL_CHARS, 32'(sc));
        write_reg(CFG_FLOW_CHARS, 32'(fc));
        write_reg(CFG_EDIT_CHARS, ec);
        write_reg(CFG_PACKET_MODE, 32'(pm));
        write_reg(CFG_SIG_TARGET, 32'(st));
    endtask

    // all words in, all results out, then let zero-result bytes drain
    task automatic wait_line_idle();
        while (byte_q.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // biased toward the currently configured special keys
    function automatic logic [7:0] pick_key();
        case ($urandom_range(0, 7))
            0: return shadow_cfg.signal_chars[8 * $urandom_range(0, 2) +: 8];
            1: return shadow_cfg.flow_chars[8 * $urandom_range(0, 1) +: 8];
            2: return shadow_cfg.edit_chars[8 * $urandom_range(0, 3) +: 8];
            3: return $urandom_range(0, 1) ? CH_CR : CH_NL;
            4: return 8'($urandom_range(0, 31));
            5: return CH_DEL;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_terminator();
        case ($urandom_range(0, 3))
            0: return CH_NL;
            1: return shadow_cfg.edit_chars[31:24];
            2: return shadow_cfg.edit_chars[7:0];
            default: return shadow_cfg.edit_chars[23:16];
        endcase
    endfunction

    // mostly short lines with random content and an ending key, some loose keys
    task automatic queue_random(input int n);
        int left;
        int len;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 3) != 0) begin
                len = $urandom_range(0, 10);
                repeat (len) begin
                    if ($urandom_range(0, 6) == 0)
                        byte_q.push_back(pick_key());
                    else
                        byte_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
                byte_q.push_back(pick_terminator());
                left -= len + 1;
            end else begin
                byte_q.push_back(pick_key());
                left--;
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] first_keys[] = '{
            "h", "i", CH_DEL, 8'h01, 8'h00, 8'h04, CH_DEL, 8'h15, "x", 8'h15,
            8'h13, "q", 8'h13, 8'h11, 8'h11, CH_CR, 8'h03, 8'hFF, CH_TAB, CH_NL};
        logic [7:0] packet_keys[] = '{
            8'h8D, CH_NL, 8'h13, "b", 8'h11, 8'h84, 8'h03, 8'h9C};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: editing, echo forms, flow keys, signal without target
        foreach (first_keys[i]) byte_q.push_back(first_keys[i]);
        wait_line_idle();

        // strip, CR ignore, NL to CR, packet mode, signal target
        apply_settings(5'h1F, 7'h7F, 24'h1A1C03, 16'h1113, 32'h00157F04, 1'b1, 1'b1);
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        foreach (packet_keys[i]) byte_q.push_back(packet_keys[i]);
        wait_line_idle();

        // overfull line, then sink hold-off while bytes keep coming
        apply_settings(5'h14, 7'h7F, 24'h1A1C03, 16'h1113, 32'h00157F04, 1'b0, 1'b1);
        repeat (64) byte_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        byte_q.push_back(CH_NL);
        hold_req++;
        queue_random(10);
        wait_line_idle();
        queue_random(10);
        wait_line_idle();

        apply_settings(5'h1F, 7'h7F, 24'h1A1C03, 16'h1113, 32'h0A7F0415, 1'b1, 1'b1);
        queue_random(18);
        wait_line_idle();

        // raw mode, all flags and keys at zero
        apply_settings(5'h00, 7'h00, 24'h000000, 16'h0000, 32'h00000000, 1'b0, 1'b0);
        queue_random(18);
        wait_line_idle();

        // DEL ends a line, all signal and flow keys at 0xFF
        apply_settings(5'h10, 7'h2E, 24'hFFFFFF, 16'hFFFF, 32'h7F150804, 1'b1, 1'b1);
        queue_random(18);
        wait_line_idle();

        apply_settings(5'($urandom), 7'($urandom), 24'($urandom), 16'($urandom), $urandom,
                       1'($urandom), 1'($urandom));
        queue_random(18);
        wait_line_idle();

        // no echo, all edit keys 0xFF
        apply_settings(5'h0A, 7'h5B, 24'h000000, 16'h0000, 32'hFFFFFFFF, 1'b0, 1'b1);
        queue_random(18);
        wait_line_idle();

        bursts_on = 1'b0;
        apply_settings(5'h14, 7'h7F, 24'h1A1C03, 16'h1113, 32'h00157F04, 1'b1, 1'b1);
        queue_random(18);
        wait_line_idle();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
sv/tild_pkg.sv
sv/tild_front.sv
sv/tild_cmd_fifo.sv
sv/tild_back.sv
sv/terminal_input_line_discipline_top.sv
sv/tild_checker.sv
verif/testbench.sv
